>>> rtl/ipc_pkg.sv
`default_nettype none
package ipc_pkg;

    // Input beat layout (tdata), lowest bit first
    localparam int WORD_W  = 32;
    localparam int VB_W    = 3;
    localparam int PLEN_W  = 16;
    localparam int NH_W    = 8;
    localparam int CSUM_W  = 16;

    localparam int WORD_LSB = 0;
    localparam int VB_LSB   = WORD_LSB + WORD_W;
    localparam int PLEN_LSB = VB_LSB + VB_W;
    localparam int NH_LSB   = PLEN_LSB + PLEN_W;
    localparam int EXP_LSB  = NH_LSB + NH_W;
    localparam int IN_BITS  = EXP_LSB + CSUM_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output beat layout (tdata): checksum, then match flag
    localparam int OUT_BITS   = CSUM_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // tuser codes for the word kind
    localparam logic FUNC_ADDR    = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    localparam logic [CSUM_W-1:0] CSUM_ZERO = 16'h0000;
    localparam logic [CSUM_W-1:0] CSUM_ONES = 16'hFFFF;

    // Per-beat control carried alongside the lane sums
    typedef struct packed {
        logic              last;
        logic [CSUM_W-1:0] expected;
    } t_s1_ctrl;

    // Ones' complement add with end-around carry, result folded to 16 bits
    function automatic logic [CSUM_W-1:0] oc_add16(input logic [CSUM_W-1:0] a,
                                                   input logic [CSUM_W-1:0] b);
        logic [CSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, s[CSUM_W]};
    endfunction

    // Byte enables for a word, MSB byte first; address words use all bytes
    function automatic logic [3:0] byte_en(input logic func,
                                           input logic [VB_W-1:0] vb);
        logic [3:0] be;
        be = 4'b1111;
        if (func == FUNC_PAYLOAD) begin
            case (vb)
                3'd0:    be = 4'b0000;
                3'd1:    be = 4'b1000;
                3'd2:    be = 4'b1100;
                3'd3:    be = 4'b1110;
                default: be = 4'b1111;
            endcase
        end
        return be;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ipc_lane.sv
`default_nettype none
// One checksum lane: masks a 32-bit operand by bytes and folds its two
// 16-bit halves into a ones' complement partial sum.
module ipc_lane (
    input  wire logic [ipc_pkg::WORD_W-1:0] i_operand,
    input  wire logic [3:0]                 i_byte_en,
    output logic [ipc_pkg::CSUM_W-1:0]      o_sum
);
    import ipc_pkg::*;

    logic [WORD_W-1:0] masked;

    // byte masking, bit 3 of the enable covers the top byte
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            masked[i*8 +: 8] = i_operand[i*8 +: 8] & {8{i_byte_en[i]}};
        end
    end

    assign o_sum = oc_add16(masked[WORD_W-1:CSUM_W], masked[CSUM_W-1:0]);

endmodule
`default_nettype wire

>>> rtl/ipc_merge.sv
`default_nettype none
// Merge stage: folds the word lane into the running sum, and on the last
// beat adds the trailer lane, complements and drives the result register.
module ipc_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s1_valid,
    input  wire ipc_pkg::t_s1_ctrl           i_s1_ctrl,
    input  wire logic [ipc_pkg::CSUM_W-1:0]  i_word_sum,
    input  wire logic [ipc_pkg::CSUM_W-1:0]  i_trail_sum,
    output logic                             o_s1_consume,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ipc_pkg::CSUM_W-1:0]       o_checksum,
    output logic                             o_match
);
    import ipc_pkg::*;

    logic [CSUM_W-1:0] r_acc, n_acc;
    logic              r_valid, n_valid;
    logic [CSUM_W-1:0] r_csum, n_csum;
    logic              r_match, n_match;

    logic [CSUM_W-1:0] acc_sum;
    logic [CSUM_W-1:0] fin_sum;
    logic [CSUM_W-1:0] res;
    logic              load_out;

    // non-last beats never need the output slot
    assign o_s1_consume = i_s1_valid && (!i_s1_ctrl.last || !r_valid || i_ready);
    assign load_out     = o_s1_consume && i_s1_ctrl.last;

    // accumulate and finish
    always_comb begin
        acc_sum = oc_add16(r_acc, i_word_sum);
        fin_sum = oc_add16(acc_sum, i_trail_sum);
        res     = ~fin_sum;
        if (res == CSUM_ZERO) begin
            res = CSUM_ONES;
        end else if (res == CSUM_ONES) begin
            res = CSUM_ZERO;
        end
    end

    // next values
    always_comb begin
        n_acc   = r_acc;
        n_valid = r_valid && !i_ready;
        n_csum  = r_csum;
        n_match = r_match;
        if (o_s1_consume) begin
            n_acc = i_s1_ctrl.last ? CSUM_ZERO : acc_sum;
        end
        if (load_out) begin
            n_valid = 1'b1;
            n_csum  = res;
            n_match = (res == i_s1_ctrl.expected);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= CSUM_ZERO;
            r_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_valid <= n_valid;
        end
    end

    // payload of the result register
    always_ff @(posedge i_clk) begin
        r_csum  <= n_csum;
        r_match <= n_match;
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_csum;
    assign o_match    = r_match;

endmodule
`default_nettype wire

>>> rtl/ipv6_pseudo_header_checksum.sv
`default_nettype none
// IPv6 upper-layer checksum over the pseudo-header and payload.
// Slave stream: one beat per 32-bit word. tuser selects address word (0) or
// payload word (1); tlast closes the packet. Payload length, next header and
// the expected checksum are taken from the tlast beat.
// Master stream: one beat per packet, carrying the final checksum (with the
// 0x0000/0xFFFF swap) and a flag that it equals the expected value.
// Throughput: one word per cycle unless a tlast beat waits for the result
// slot; two lanes fold the word halves and the length/next-header trailer
// in parallel, and a merge stage closes the 16-bit end-around-carry loop on
// the running sum. The tlast beat passes the lane register and the merge
// stage into the result register, where the result beat is then valid.
// Reset clears the running sum and empties the pipeline and result register.
// When the receiver stalls, the result waits in its register; non-last words
// keep flowing into the sum, and only a second tlast beat waits for the slot.
module ipv6_pseudo_header_checksum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] word, [34:32] valid_bytes, [50:35] payload_length,
    // [58:51] next_header, [74:59] expected_checksum, rest zero
    input  wire logic [ipc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] func
    input  wire logic [0:0]                     i_s_axis_tuser,
    input  wire logic                           i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [15:0] checksum, [16] matches_res, rest zero
    output logic [ipc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import ipc_pkg::*;

    logic [WORD_W-1:0] in_word;
    logic [VB_W-1:0]   in_vb;
    logic [WORD_W-1:0] trail_operand;
    logic [3:0]        word_be;
    logic [CSUM_W-1:0] word_sum;
    logic [CSUM_W-1:0] trail_sum;
    logic              accept;
    logic              s1_consume;
    logic [CSUM_W-1:0] out_csum;
    logic              out_match;

    logic              r_s1_valid;
    t_s1_ctrl          r_s1_ctrl;
    logic [CSUM_W-1:0] r_word_sum;
    logic [CSUM_W-1:0] r_trail_sum;

    assign in_word       = i_s_axis_tdata[WORD_LSB +: WORD_W];
    assign in_vb         = i_s_axis_tdata[VB_LSB +: VB_W];
    assign word_be       = byte_en(i_s_axis_tuser[0], in_vb);
    assign trail_operand = {i_s_axis_tdata[PLEN_LSB +: PLEN_W],
                            {(CSUM_W-NH_W){1'b0}}, i_s_axis_tdata[NH_LSB +: NH_W]};

    // word lane and trailer lane
    ipc_lane u_word_lane (
        .i_operand (in_word),
        .i_byte_en (word_be),
        .o_sum     (word_sum)
    );

    ipc_lane u_trail_lane (
        .i_operand (trail_operand),
        .i_byte_en (4'b1111),
        .o_sum     (trail_sum)
    );

    assign o_s_axis_tready = !r_s1_valid || s1_consume;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // lane register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctrl.last     <= i_s_axis_tlast;
            r_s1_ctrl.expected <= i_s_axis_tdata[EXP_LSB +: CSUM_W];
            r_word_sum         <= word_sum;
            r_trail_sum        <= trail_sum;
        end
    end

    ipc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (r_s1_valid),
        .i_s1_ctrl    (r_s1_ctrl),
        .i_word_sum   (r_word_sum),
        .i_trail_sum  (r_trail_sum),
        .o_s1_consume (s1_consume),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_checksum   (out_csum),
        .o_match      (out_match)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_match, out_csum};

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
    import ipc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 1350;
    localparam int HOLD_CYCLES = 400;

    // One slave beat, unpacked
    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] word;
        logic [VB_W-1:0]   vb;
        logic              last;
        logic [PLEN_W-1:0] plen;
        logic [NH_W-1:0]   nh;
        logic [CSUM_W-1:0] expc;
    } t_beat;

    // One master beat, unpacked
    typedef struct packed {
        logic [CSUM_W-1:0] csum;
        logic              match;
    } t_sum_res;

    // Running ones' complement sum of the packet in flight, plus the
    // checksums still owed by the block
    class csum_tracker;
        logic [CSUM_W-1:0] acc;
        t_sum_res          owed_q[$];
        int                n_bad;
        int                n_checked;

        function new();
            acc = '0;
            n_bad = 0;
            n_checked = 0;
        endfunction

        // 16-bit add with the carry wrapped back in
        function logic [CSUM_W-1:0] wrap_add(logic [CSUM_W-1:0] a, logic [CSUM_W-1:0] b);
            int unsigned t;
            t = 32'(a) + 32'(b);
            t = (t & 32'hFFFF) + (t >> 16);
            return t[CSUM_W-1:0];
        endfunction

        // Fold one beat into the sum; returns 1 and the result on a tlast beat
        function bit fold_beat(t_beat b, output t_sum_res r);
            logic [WORD_W-1:0] w;
            logic [CSUM_W-1:0] s;
            w = b.word;
            // payload bytes past valid_bytes count as zero
            if (b.func == FUNC_PAYLOAD) begin
                case (b.vb)
                    3'd0: w = '0;
                    3'd1: w = w & 32'hFF00_0000;
                    3'd2: w = w & 32'hFFFF_0000;
                    3'd3: w = w & 32'hFFFF_FF00;
                    default: ;
                endcase
            end
            s = wrap_add(acc, w[31:16]);
            s = wrap_add(s, w[15:0]);
            r = '0;
            if (!b.last) begin
                acc = s;
                return 1'b0;
            end
            s = wrap_add(s, b.plen);
            s = wrap_add(s, {8'h00, b.nh});
            s = ~s;
            if (s == CSUM_ZERO)
                s = CSUM_ONES;
            else if (s == CSUM_ONES)
                s = CSUM_ZERO;
            r.csum = s;
            r.match = (s == b.expc);
            acc = '0;
            return 1'b1;
        endfunction

        function void take_beat(t_beat b);
            t_sum_res r;
            if (fold_beat(b, r))
                owed_q.push_back(r);
        endfunction

        function void flag_miss(string what, int unsigned want, int unsigned got);
            n_bad++;
            if (n_bad <= 10)
                $display("MISMATCH %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] d);
            t_sum_res want;
            n_checked++;
            if (owed_q.size() == 0) begin
                flag_miss("result with none pending", 0, 32'(d));
                return;
            end
            want = owed_q.pop_front();
            if (d[CSUM_W-1:0] !== want.csum)
                flag_miss("checksum", 32'(want.csum), 32'(d[CSUM_W-1:0]));
            if (d[CSUM_W] !== want.match)
                flag_miss("matches_res", 32'(want.match), 32'(d[CSUM_W]));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    wire                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [0:0]            i_s_axis_tuser;
    logic                  i_s_axis_tlast;
    wire                   o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    wire [OUT_DATA_W-1:0]  o_m_axis_tdata;

    ipv6_pseudo_header_checksum uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    csum_tracker sums     = new();
    csum_tracker pkt_calc = new();

    int n_beats_in;
    int n_driven;
    int rx_hold;
    int rx_stall;
    bit rx_took;
    bit rx_fast;
    bit tx_fast;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: note accepted input beats, check result beats
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                b.func = i_s_axis_tuser[0];
                b.word = i_s_axis_tdata[WORD_LSB +: WORD_W];
                b.vb   = i_s_axis_tdata[VB_LSB +: VB_W];
                b.last = i_s_axis_tlast;
                b.plen = i_s_axis_tdata[PLEN_LSB +: PLEN_W];
                b.nh   = i_s_axis_tdata[NH_LSB +: NH_W];
                b.expc = i_s_axis_tdata[EXP_LSB +: CSUM_W];
                sums.take_beat(b);
                n_beats_in++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sums.check_beat(o_m_axis_tdata);
                rx_took = 1'b1;
            end
        end
    end

    // Receiver: random stall per result, plus a long hold when asked
    initial begin
        i_m_axis_tready = 1'b0;
        rx_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_took) begin
                rx_took = 1'b0;
                rx_stall = rx_fast ? 0 : $urandom_range(0, 11);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with no beat on either side
    initial begin
        int idle_cnt;
        idle_cnt = 0;
        @(posedge i_rst_n);
        while (idle_cnt < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Offer one beat after a random gap and hold it until taken
    task automatic drive_beat(t_beat b);
        int gap;
        logic [IN_DATA_W-1:0] d;
        gap = tx_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        d = '0;
        d[WORD_LSB +: WORD_W] = b.word;
        d[VB_LSB +: VB_W]     = b.vb;
        d[PLEN_LSB +: PLEN_W] = b.plen;
        d[NH_LSB +: NH_W]     = b.nh;
        d[EXP_LSB +: CSUM_W]  = b.expc;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= b.func;
        i_s_axis_tlast  <= b.last;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Send one beat; on tlast optionally make expected_checksum the right one
    task automatic put_beat(t_beat b, bit make_match);
        t_sum_res r;
        if (pkt_calc.fold_beat(b, r) && make_match)
            b.expc = r.csum;
        n_driven++;
        drive_beat(b);
    endtask

    // Stop offering and wait until every owed checksum has come out
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (sums.pending() != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_beat mk_beat(logic func, logic [WORD_W-1:0] word,
                                      logic [VB_W-1:0] vb, logic last);
        t_beat b;
        b.func = func;
        b.word = word;
        b.vb   = vb;
        b.last = last;
        b.plen = 16'($urandom_range(0, 65535));
        b.nh   = 8'($urandom_range(0, 255));
        b.expc = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    // Main stimulus
    initial begin
        t_beat b;
        int kind;
        int n_pay;
        int n_len;
        int pkt_no;
        int fails;

        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_s_axis_tlast = 1'b0;
        rx_hold = 0;
        rx_took = 1'b0;
        rx_fast = 1'b0;
        tx_fast = 1'b0;
        n_beats_in = 0;
        n_driven = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All-ones words and trailer: maximum carries
        b = mk_beat(FUNC_ADDR, '1, 3'd4, 1'b0);
        put_beat(b, 1'b0);
        put_beat(b, 1'b0);
        b = mk_beat(FUNC_PAYLOAD, '1, 3'd4, 1'b1);
        b.plen = '1;
        b.nh = '1;
        put_beat(b, 1'b1);

        // Sum of zero: complement gives all ones, swapped to zero
        b = mk_beat(FUNC_PAYLOAD, '0, 3'd4, 1'b1);
        b.plen = '0;
        b.nh = '0;
        b.expc = '0;
        put_beat(b, 1'b0);

        // Sum of all ones: complement gives zero, swapped to all ones
        b = mk_beat(FUNC_PAYLOAD, 32'hFFFF_0000, 3'd2, 1'b1);
        b.plen = '0;
        b.nh = '0;
        b.expc = '0;
        put_beat(b, 1'b0);

        // Every valid_bytes code but 4, short words before the last one too
        for (int v = 1; v <= 8; v++) begin
            if (v != 4) begin
                b = mk_beat(FUNC_PAYLOAD, 32'hAABB_CCDD, v[2:0], v == 8);
                put_beat(b, 1'b1);
            end
        end

        // Address word carrying tlast
        b = mk_beat(FUNC_ADDR, 32'h1234_5678, 3'd0, 1'b1);
        put_beat(b, 1'b1);

        // Address word with a short valid_bytes (ignored), then payload
        b = mk_beat(FUNC_ADDR, 32'hFEDC_BA98, 3'd1, 1'b0);
        put_beat(b, 1'b0);
        b = mk_beat(FUNC_PAYLOAD, 32'h8001_7FFE, 3'd4, 1'b1);
        put_beat(b, 1'b1);

        // Small packet of four address words, ending in three bytes
        for (int i = 0; i < 4; i++) begin
            b = mk_beat(FUNC_ADDR, pick_word(), 3'd4, 1'b0);
            put_beat(b, 1'b0);
        end
        b = mk_beat(FUNC_PAYLOAD, pick_word(), 3'd3, 1'b1);
        put_beat(b, 1'b1);
        wait_drain();

        // Random packets
        n_driven = 0;
        pkt_no = 0;
        while (n_driven < RANDOM_BEATS) begin
            // change the idle pattern every so often
            if (pkt_no % 12 == 0) begin
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
            end

            // receiver holds off while the sender keeps pushing short packets
            if (pkt_no == 45) begin
                wait_drain();
                tx_fast = 1'b1;
                rx_hold = HOLD_CYCLES;
                for (int i = 0; i < 12; i++) begin
                    b = mk_beat(1'($urandom_range(0, 1)), pick_word(),
                                3'($urandom_range(0, 7)), 1'b1);
                    put_beat(b, 1'($urandom_range(0, 1)));
                end
                tx_fast = 1'b0;
                wait_drain();
            end

            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // well-formed: eight address words, then payload
                n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                for (int i = 0; i < 8; i++) begin
                    b = mk_beat(FUNC_ADDR, pick_word(), 3'($urandom_range(0, 7)), 1'b0);
                    put_beat(b, 1'b0);
                end
                for (int i = 0; i < n_pay; i++) begin
                    b = mk_beat(FUNC_PAYLOAD, pick_word(), 3'd4, i == n_pay - 1);
                    if (b.last) begin
                        b.vb = 3'($urandom_range(1, 4));
                        if ($urandom_range(0, 1))
                            b.plen = 16'(4 * (n_pay - 1) + int'(b.vb));
                    end
                    put_beat(b, 1'($urandom_range(0, 1)));
                end
            end else begin
                // noise: any kind, any valid_bytes, lengths of 1 to 12 words
                n_len = (kind == 7) ? $urandom_range(1, 3) : $urandom_range(1, 12);
                for (int i = 0; i < n_len; i++) begin
                    b = mk_beat(1'($urandom_range(0, 1)), pick_word(),
                                3'($urandom_range(0, 7)), i == n_len - 1);
                    put_beat(b, 1'($urandom_range(0, 1)));
                end
            end
            pkt_no++;
            if ($urandom_range(0, 19) == 0)
                wait_drain();
        end

        // Drain and let the pipeline settle
        wait_drain();
        repeat (8) @(negedge i_clk);

        fails = sums.n_bad + sums.pending();
        $display("Covered %0d input beats and %0d checksum results (%0d mismatches),",
                 n_beats_in, sums.n_checked, sums.n_bad);
        $display("with random idling, a long receiver hold-off and drain pauses.");
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/ipc_pkg.sv
rtl/ipc_lane.sv
rtl/ipc_merge.sv
rtl/ipv6_pseudo_header_checksum.sv
sim/testbench.sv
